// File: src/md5_pkg.sv
// shared types, constants and round tables for the md5 digest unit
// no dependencies; used by md5_ctrl, md5_dpath and the top level
`timescale 1ns / 1ps
`default_nettype none

package md5_pkg;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       write_byte;
        logic       write_pad;
        logic       write_len;
        logic       round_en;
        logic [5:0] round_idx;
        logic       fold;
        logic       restart;
        logic [1:0] out_idx;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic pos_last;   // byte position in block is 63
        logic pos_high;   // byte position in block is 56 or more
    } stat_t;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [5:0] LAST_ROUND  = 6'd63;
    localparam logic [5:0] LAST_POS    = 6'd63;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [1:0] LAST_WORD   = 2'd3;
    localparam logic [3:0] LEN_LO_WORD = 4'd14;
    localparam logic [3:0] LEN_HI_WORD = 4'd15;

    // per-round additive constant
    function automatic logic [31:0] round_add(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // per-round left rotate amount
    function automatic logic [4:0] round_rot(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'b0000: s = 5'd7;   4'b0001: s = 5'd12;
            4'b0010: s = 5'd17;  4'b0011: s = 5'd22;
            4'b0100: s = 5'd5;   4'b0101: s = 5'd9;
            4'b0110: s = 5'd14;  4'b0111: s = 5'd20;
            4'b1000: s = 5'd4;   4'b1001: s = 5'd11;
            4'b1010: s = 5'd16;  4'b1011: s = 5'd23;
            4'b1100: s = 5'd6;   4'b1101: s = 5'd10;
            4'b1110: s = 5'd15;  4'b1111: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word used by each round, arithmetic wraps in four bits
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] rl;
        logic [3:0] w;
        rl = r[3:0];
        case (r[5:4])
            2'd0:    w = rl;
            2'd1:    w = rl * 4'd5 + 4'd1;
            2'd2:    w = rl * 4'd3 + 4'd5;
            2'd3:    w = rl * 4'd7;
            default: w = rl;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: src/md5_ctrl.sv
// control state machine for the md5 digest unit: byte intake, padding,
// round sequencing and digest output; depends on md5_pkg
`timescale 1ns / 1ps
`default_nettype none

module md5_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_present,
    input  wire logic          in_end,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [1:0]         word_index,
    output logic               last_word,
    input  wire md5_pkg::stat_t stat,
    output md5_pkg::cmd_t      cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_LEN   = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_FOLD  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] ret_reg, ret_next;     // where to go after a compression
    logic [5:0] round_reg, round_next;
    logic [1:0] idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.out_idx = idx_reg;
        in_ready   = (state_reg == S_IDLE);
        out_valid  = (state_reg == S_OUT);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.write_byte = in_present;
                    if (in_present && stat.pos_last)
                    begin
                        state_next = S_ROUND;
                        ret_next   = in_end ? S_PAD : S_IDLE;
                    end
                    else if (in_end)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                cmd.write_pad = 1'b1;
                if (stat.pos_high)
                begin
                    // no room for the length, an extra block is needed
                    state_next = S_ROUND;
                    ret_next   = S_LEN;
                end
                else
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                cmd.write_len = 1'b1;
                state_next    = S_ROUND;
                ret_next      = S_OUT;
            end
            S_ROUND:
            begin
                cmd.round_en  = 1'b1;
                cmd.round_idx = round_reg;
                round_next    = round_reg + 6'd1;
                if (round_reg == md5_pkg::LAST_ROUND)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = ret_reg;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == md5_pkg::LAST_WORD)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign word_index = idx_reg;
    assign last_word  = (idx_reg == md5_pkg::LAST_WORD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            round_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

// File: src/md5_dpath.sv
// datapath of the md5 digest unit: block buffer, byte count, round unit
// and chaining words; depends on md5_pkg
`timescale 1ns / 1ps
`default_nettype none

module md5_dpath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [7:0]    data_byte,
    input  wire md5_pkg::cmd_t cmd,
    output md5_pkg::stat_t     stat,
    output logic [31:0]        digest_word
);

    logic [31:0] buf_reg [16];
    logic [31:0] buf_next [16];
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [60:0] count_reg, count_next;

    logic [5:0]  pos;
    logic [63:0] len_bits;
    logic [31:0] fn;
    logic [31:0] m_word;
    logic [31:0] sum;
    logic [63:0] rot_dbl;
    logic [31:0] b_round;
    logic [31:0] fold_sum [4];

    assign pos      = count_reg[5:0];
    assign len_bits = {count_reg, 3'b000};

    assign stat.pos_last = (pos == md5_pkg::LAST_POS);
    assign stat.pos_high = (pos >= md5_pkg::LEN_POS);

    // one md5 round
    always_comb
    begin
        case (cmd.round_idx[5:4])
            2'd0:    fn = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    fn = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    fn = b_reg ^ c_reg ^ d_reg;
            2'd3:    fn = c_reg ^ (b_reg | ~d_reg);
            default: fn = '0;
        endcase
    end

    assign m_word  = buf_reg[md5_pkg::msg_index(cmd.round_idx)];
    assign sum     = a_reg + fn + md5_pkg::round_add(cmd.round_idx) + m_word;
    assign rot_dbl = {sum, sum} << md5_pkg::round_rot(cmd.round_idx);
    assign b_round = b_reg + rot_dbl[63:32];

    assign fold_sum[0] = chain_reg[0] + a_reg;
    assign fold_sum[1] = chain_reg[1] + b_reg;
    assign fold_sum[2] = chain_reg[2] + c_reg;
    assign fold_sum[3] = chain_reg[3] + d_reg;

    always_comb
    begin
        buf_next   = buf_reg;
        chain_next = chain_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        count_next = count_reg;

        if (cmd.write_byte)
        begin
            buf_next[pos[5:2]][{pos[1:0], 3'b000} +: 8] = data_byte;
            count_next = count_reg + 61'd1;
        end
        if (cmd.write_pad)
        begin
            buf_next[pos[5:2]][{pos[1:0], 3'b000} +: 8] = md5_pkg::PAD_BYTE;
        end
        if (cmd.write_len)
        begin
            buf_next[md5_pkg::LEN_LO_WORD] = len_bits[31:0];
            buf_next[md5_pkg::LEN_HI_WORD] = len_bits[63:32];
        end
        if (cmd.round_en)
        begin
            a_next = d_reg;
            d_next = c_reg;
            c_next = b_reg;
            b_next = b_round;
        end
        if (cmd.fold)
        begin
            // working words track the chaining words between blocks
            for (int i = 0; i < 16; i++)
            begin
                buf_next[i] = '0;
            end
            chain_next = fold_sum;
            a_next     = fold_sum[0];
            b_next     = fold_sum[1];
            c_next     = fold_sum[2];
            d_next     = fold_sum[3];
        end
        if (cmd.restart)
        begin
            chain_next[0] = md5_pkg::IV_A;
            chain_next[1] = md5_pkg::IV_B;
            chain_next[2] = md5_pkg::IV_C;
            chain_next[3] = md5_pkg::IV_D;
            a_next        = md5_pkg::IV_A;
            b_next        = md5_pkg::IV_B;
            c_next        = md5_pkg::IV_C;
            d_next        = md5_pkg::IV_D;
            count_next    = '0;
        end
    end

    assign digest_word = chain_reg[cmd.out_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                buf_reg[i] <= '0;
            end
            chain_reg[0] <= md5_pkg::IV_A;
            chain_reg[1] <= md5_pkg::IV_B;
            chain_reg[2] <= md5_pkg::IV_C;
            chain_reg[3] <= md5_pkg::IV_D;
            a_reg        <= md5_pkg::IV_A;
            b_reg        <= md5_pkg::IV_B;
            c_reg        <= md5_pkg::IV_C;
            d_reg        <= md5_pkg::IV_D;
            count_reg    <= '0;
        end
        else
        begin
            buf_reg   <= buf_next;
            chain_reg <= chain_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            c_reg     <= c_next;
            d_reg     <= d_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: src/md5_message_digest_unit.sv
// sequence: bytes are taken one per cycle while idle; the byte that fills a
// block starts 64 rounds of the single round unit, then the fold
// end of message: pad step, length step, one compression per final block (two
// blocks when the pad byte lands at position 56 or later), then four outputs
// no byte is taken while a block is compressed by the one-round-per-cycle unit
// reset: asynchronous, clears count and buffer and loads the initial words
`timescale 1ns / 1ps
`default_nettype none

module md5_message_digest_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] byte_present
    input  wire logic        s_axis_tlast,   // end_of_message
    // digest stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [1:0]       m_axis_tuser,   // [1:0] word_index
    output logic             m_axis_tlast    // last_word
);

    md5_pkg::cmd_t  cmd;
    md5_pkg::stat_t stat;

    // sequencer: intake, padding steps, round count, output index
    md5_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_present (s_axis_tuser[0]),
        .in_end     (s_axis_tlast),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .word_index (m_axis_tuser),
        .last_word  (m_axis_tlast),
        .stat       (stat),
        .cmd        (cmd)
    );

    // buffer, byte count, round unit and chaining words
    // the digest word is read straight from the chaining registers,
    // which hold steady while a transfer waits
    md5_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (s_axis_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .digest_word (m_axis_tdata)
    );

endmodule

`default_nettype wire
